>>> hw/rtl/comp_pkg.sv
// Package for the cache miss profiler: constants, field widths and controller states.
// Used by the top, the controller, the datapath and the directories; it depends on nothing.
`default_nettype none
package comp_pkg;
  localparam int AddrW = 16;
  localparam int CountW = 16;
  localparam int FaWaysDef = 128;
  localparam int DmLinesDef = 128;
  localparam int TwWaysDef = 128;
  localparam int FwWaysDef = 64;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FILL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [AddrW-1:0] address;
  } req_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic fill;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
  } stat_t;
endpackage
`default_nettype wire

>>> hw/rtl/comp_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
`default_nettype none
interface comp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cache_organization_miss_profiler_top.sv
// Top level of the cache miss profiler: controller plus datapath on valid/ready channels.
// Depends on comp_pkg, comp_if, comp_ctrl and comp_datapath.
//
//   channel  dir  payload
//   in_req   in   address[15:0]
//   out_res  out  fa/dm/tw/fw_miss, fa/dm/tw/fw_miss_count[15:0]
//
// The scan of the widest directory, one tag RAM entry per cycle, sets how long one
// request takes. Reset clears the fill counts, the direct-mapped valid bits and the
// totals at once, with no clearing pass.
// A stalled result holds and blocks the next request.
`default_nettype none
module cache_organization_miss_profiler_top import comp_pkg::*; #(
  parameter int FaWays = FaWaysDef,
  parameter int DmLines = DmLinesDef,
  parameter int TwWays = TwWaysDef,
  parameter int FwWays = FwWaysDef
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  comp_if.sink     in_req,
  comp_if.source   out_res
);
  cmd_t       cmd;
  stat_t      stat;
  logic [3:0] miss;

  comp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_req.valid), .in_ready_o(in_req.ready),
    .out_valid_o(out_res.valid), .out_ready_i(out_res.ready),
    .stat_i(stat), .cmd_o(cmd));

  comp_datapath #(.FaWays(FaWays), .DmLines(DmLines), .TwWays(TwWays),
                  .FwWays(FwWays)) u_dp (
    .clk_i, .rst_ni, .addr_i(in_req.data.address), .cmd_i(cmd), .stat_o(stat),
    .miss_o(miss),
    .fa_cnt_o(out_res.data.fa_miss_count), .dm_cnt_o(out_res.data.dm_miss_count),
    .tw_cnt_o(out_res.data.tw_miss_count), .fw_cnt_o(out_res.data.fw_miss_count));

  assign out_res.data.fa_miss = miss[0];
  assign out_res.data.dm_miss = miss[1];
  assign out_res.data.tw_miss = miss[2];
  assign out_res.data.fw_miss = miss[3];

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_req.ready && out_res.valid)) else $error("request and result overlap");
  a_fill_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fill |=> out_res.valid) else $error("fill not followed by result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && !out_res.ready |=> out_res.valid && $stable(out_res.data))
    else $error("result changed while stalled");
endmodule
`default_nettype wire

>>> hw/rtl/comp_ram.sv
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module comp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]              rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/comp_assoc.sv
// One associative tag directory: tag RAM, per-set fill counters and way scan.
// Depends on comp_pkg and comp_ram.
`default_nettype none
module comp_assoc import comp_pkg::*; #(
  parameter int Ways = 128,
  parameter int Sets = 1,
  parameter int TagW = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     scan_i,
  input  wire logic                     fill_i,
  input  wire logic [$clog2(Ways)-1:0]  way_i,
  input  wire logic [$clog2(Sets > 1 ? Sets : 2)-1:0] set_i,
  input  wire logic [TagW-1:0]          tag_i,
  output logic                          miss_o
);
  localparam int SetW = $clog2(Sets > 1 ? Sets : 2);
  localparam int WayW = $clog2(Ways);
  localparam int FillW = $clog2(Ways + 1);
  localparam int Depth = Ways * Sets;
  localparam int AW = $clog2(Depth);

  logic [FillW-1:0] fill_q [2**SetW];
  logic [FillW-1:0] fill_cnt;
  logic [TagW-1:0]  rdata;
  logic             hit_q, cmp_q;
  logic [WayW-1:0]  cmp_way_q;
  logic [AW-1:0]    addr;
  logic [WayW-1:0]  addr_way;
  logic             free;
  logic             we;

  function automatic logic [AW-1:0] idx(logic [SetW-1:0] s, logic [WayW-1:0] w);
    logic [AW+SetW-1:0] t;
    t = ({{AW{1'b0}}, s} * (AW+SetW)'(Ways)) + (AW+SetW)'(w);
    return t[AW-1:0];
  endfunction

  // Ways fill in order and are never freed, so the valid ways of a set are
  // exactly those below its fill count.
  assign fill_cnt = fill_q[set_i];
  assign free = fill_cnt < FillW'(Ways);
  assign addr_way = fill_i ? WayW'(fill_cnt) : way_i;
  assign addr = idx(set_i, addr_way);
  assign we = fill_i && !hit_q && free;
  assign miss_o = !hit_q;

  comp_ram #(.Width(TagW), .Depth(Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(tag_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '{default: '0};
      hit_q <= 1'b0;
      cmp_q <= 1'b0;
      cmp_way_q <= '0;
    end else begin
      cmp_q <= scan_i;
      cmp_way_q <= way_i;
      if (start_i) begin
        hit_q <= 1'b0;
      end
      if (cmp_q && FillW'(cmp_way_q) < fill_cnt && rdata == tag_i) begin
        hit_q <= 1'b1;
      end
      if (we) begin
        fill_q[set_i] <= fill_cnt + 1'b1;
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/comp_datapath.sv
// Datapath: address register, four directories, miss totals and result register.
// Depends on comp_pkg, comp_assoc and comp_ram.
`default_nettype none
module comp_datapath import comp_pkg::*; #(
  parameter int FaWays = FaWaysDef,
  parameter int DmLines = DmLinesDef,
  parameter int TwWays = TwWaysDef,
  parameter int FwWays = FwWaysDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire cmd_t             cmd_i,
  output stat_t                 stat_o,
  output logic [3:0]            miss_o,
  output logic [CountW-1:0]     fa_cnt_o,
  output logic [CountW-1:0]     dm_cnt_o,
  output logic [CountW-1:0]     tw_cnt_o,
  output logic [CountW-1:0]     fw_cnt_o
);
  localparam int MaxWays = (FaWays > TwWays ? FaWays : TwWays) > FwWays ?
                           (FaWays > TwWays ? FaWays : TwWays) : FwWays;
  localparam int CntW = $clog2(MaxWays + 2);
  localparam int DmW = $clog2(DmLines);

  logic [AddrW-1:0] addr_q;
  logic [CntW-1:0]  cnt_q;
  logic             fa_m, tw_m, fw_m, dm_m;
  logic [DmLines-1:0] dm_valid_q;
  logic [3:0]       dm_tag_rd;
  logic [DmW-1:0]   line;
  logic [6:0]       line_raw;
  logic [DmW-1:0]   line_lut [128];
  logic [CountW-1:0] fa_q, dm_q, tw_q, fw_q;

  for (genvar g = 0; g < 128; g++) begin : g_line
    assign line_lut[g] = DmW'(g % DmLines);
  end

  assign line_raw = addr_q[11:5];
  assign line = line_lut[line_raw];
  assign stat_o.scan_done = (cnt_q == CntW'(MaxWays + 1));

  comp_assoc #(.Ways(FaWays), .Sets(1), .TagW(11)) u_fa (
    .clk_i, .rst_ni, .start_i(cmd_i.start),
    .scan_i(cmd_i.scan && cnt_q < CntW'(FaWays)),
    .fill_i(cmd_i.fill), .way_i($clog2(FaWays)'(cnt_q)), .set_i('0),
    .tag_i(addr_q[15:5]), .miss_o(fa_m));
  comp_assoc #(.Ways(TwWays), .Sets(2), .TagW(11)) u_tw (
    .clk_i, .rst_ni, .start_i(cmd_i.start),
    .scan_i(cmd_i.scan && cnt_q < CntW'(TwWays)),
    .fill_i(cmd_i.fill), .way_i($clog2(TwWays)'(cnt_q)), .set_i(addr_q[4]),
    .tag_i(addr_q[15:5]), .miss_o(tw_m));
  comp_assoc #(.Ways(FwWays), .Sets(4), .TagW(10)) u_fw (
    .clk_i, .rst_ni, .start_i(cmd_i.start),
    .scan_i(cmd_i.scan && cnt_q < CntW'(FwWays)),
    .fill_i(cmd_i.fill), .way_i($clog2(FwWays)'(cnt_q)), .set_i(addr_q[5:4]),
    .tag_i(addr_q[15:6]), .miss_o(fw_m));

  comp_ram #(.Width(4), .Depth(DmLines)) u_dm (
    .clk_i, .we_i(cmd_i.fill && dm_m), .addr_i(line),
    .wdata_i(addr_q[15:12]), .rdata_o(dm_tag_rd));

  assign dm_m = !(dm_valid_q[line] && dm_tag_rd == addr_q[15:12]);

  function automatic logic [CountW-1:0] bump(logic [CountW-1:0] t, logic m);
    return (m && t != CountMax) ? t + 1'b1 : t;
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= addr_i;
    end
    if (cmd_i.fill) begin
      miss_o <= {fw_m, tw_m, dm_m, fa_m};
      fa_cnt_o <= bump(fa_q, fa_m);
      dm_cnt_o <= bump(dm_q, dm_m);
      tw_cnt_o <= bump(tw_q, tw_m);
      fw_cnt_o <= bump(fw_q, fw_m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      dm_valid_q <= '0;
      fa_q <= '0;
      dm_q <= '0;
      tw_q <= '0;
      fw_q <= '0;
    end else begin
      if (cmd_i.start) begin
        cnt_q <= '0;
      end else if (cmd_i.scan) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (cmd_i.fill) begin
        dm_valid_q[line] <= 1'b1;
        fa_q <= bump(fa_q, fa_m);
        dm_q <= bump(dm_q, dm_m);
        tw_q <= bump(tw_q, tw_m);
        fw_q <= bump(fw_q, fw_m);
      end
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/comp_ctrl.sv
// Controller state machine: sequences accept, way scan, fill and result handoff.
// Depends on comp_pkg.
`default_nettype none
module comp_ctrl import comp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  input  wire stat_t stat_i,
  output cmd_t       cmd_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (stat_i.scan_done) state_d = ST_DONE;
      ST_DONE: state_d = ST_FILL;
      ST_FILL: state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.start = in_valid_i;
      end
      ST_SCAN: cmd_o.scan = !stat_i.scan_done;
      ST_DONE: cmd_o = '0;
      ST_FILL: cmd_o.fill = 1'b1;
      ST_OUT: begin
        out_valid_o = 1'b1;
        cmd_o.finish = out_ready_i;
      end
      default: cmd_o = '0;
    endcase
  end
endmodule
`default_nettype wire
